FILE: design/masked_share_arith_unit_defines.svh
// Assertion macros shared by the checker of the masked share arithmetic unit.
// Stand-alone header, no dependencies; pulled in with `include.
`ifndef MASKED_SHARE_ARITH_UNIT_DEFINES_SVH
`define MASKED_SHARE_ARITH_UNIT_DEFINES_SVH

// Same-cycle implication, muted while reset is high.
`define MSAU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("msau check failed");

// Next-cycle implication, muted while reset is high.
`define MSAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("msau check failed");

// Next-cycle implication that also watches the reset cycles themselves.
`define MSAU_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("msau check failed");

`endif

FILE: design/msau_pkg.sv
// Package of the masked share arithmetic unit: field widths, operation codes
// and the payload structs. No dependencies.
`default_nettype none

package msau_pkg;

   localparam int FIELD_BITS  = 32;
   localparam int ACTION_BITS = 2;
   localparam int MAX_SHARES  = 3;
   localparam int RAND_WORDS  = 3;

   // Operation codes. Bit 1 selects multiply, so the spare code multiplies too.
   localparam logic [ACTION_BITS-1:0] ACT_ADD     = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_SUB     = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_MUL     = 2'd2;
   localparam logic [ACTION_BITS-1:0] ACT_MUL_ALT = 2'd3;

   typedef logic [FIELD_BITS-1:0] field_type;

   // Random words are ordered by pair: (0,1), (0,2), (1,2).
   typedef struct packed {
      logic [ACTION_BITS-1:0]             action;
      logic [MAX_SHARES-1:0][FIELD_BITS-1:0] a_share;
      logic [MAX_SHARES-1:0][FIELD_BITS-1:0] b_share;
      logic [RAND_WORDS-1:0][FIELD_BITS-1:0] rand_word;
   } req_payload_type;

   typedef struct packed {
      logic [MAX_SHARES-1:0][FIELD_BITS-1:0] out_share;
   } rsp_payload_type;

endpackage

`default_nettype wire

FILE: design/msau_req_if.sv
// Request channel of the masked share arithmetic unit: valid/ready plus the
// operation and operand shares. Depends on msau_pkg.
`default_nettype none

interface msau_req_if;
   logic                             valid;
   logic                             ready;
   logic [msau_pkg::ACTION_BITS-1:0] action;
   msau_pkg::field_type              a_share0;
   msau_pkg::field_type              a_share1;
   msau_pkg::field_type              a_share2;
   msau_pkg::field_type              b_share0;
   msau_pkg::field_type              b_share1;
   msau_pkg::field_type              b_share2;
   msau_pkg::field_type              rand_01;
   msau_pkg::field_type              rand_02;
   msau_pkg::field_type              rand_12;

   modport source (
      output valid, action, a_share0, a_share1, a_share2,
             b_share0, b_share1, b_share2, rand_01, rand_02, rand_12,
      input  ready
   );

   modport sink (
      input  valid, action, a_share0, a_share1, a_share2,
             b_share0, b_share1, b_share2, rand_01, rand_02, rand_12,
      output ready
   );
endinterface

`default_nettype wire

FILE: design/msau_rsp_if.sv
// Response channel of the masked share arithmetic unit: valid/ready plus the
// result shares. Depends on msau_pkg.
`default_nettype none

interface msau_rsp_if;
   logic                valid;
   logic                ready;
   msau_pkg::field_type out_share0;
   msau_pkg::field_type out_share1;
   msau_pkg::field_type out_share2;

   modport source (
      output valid, out_share0, out_share1, out_share2,
      input  ready
   );

   modport sink (
      input  valid, out_share0, out_share1, out_share2,
      output ready
   );
endinterface

`default_nettype wire

FILE: design/msau_share_alu.sv
// Share-wise add/sub and masked multiply of one request beat, all combinational.
// Depends on msau_pkg.
`default_nettype none

module msau_share_alu #(
   parameter int SHARES    = 3,
   parameter int WORD_BITS = 32
) (
   input  wire msau_pkg::req_payload_type req_data,
   output msau_pkg::rsp_payload_type      rsp_data
);

   // Everything past bit 31 is dropped at the output, so wider words add nothing.
   localparam int CALC_BITS = (WORD_BITS < msau_pkg::FIELD_BITS) ?
                              WORD_BITS : msau_pkg::FIELD_BITS;

   typedef logic [CALC_BITS-1:0] word_type;

   word_type a_word [msau_pkg::MAX_SHARES];
   word_type b_word [msau_pkg::MAX_SHARES];
   word_type r_word [msau_pkg::RAND_WORDS];
   word_type prod   [msau_pkg::MAX_SHARES][msau_pkg::MAX_SHARES];
   word_type result [msau_pkg::MAX_SHARES];

   always_comb begin
      for (int i = 0; i < msau_pkg::MAX_SHARES; i++) begin
         a_word[i] = req_data.a_share[i][CALC_BITS-1:0];
         b_word[i] = req_data.b_share[i][CALC_BITS-1:0];
      end
      for (int p = 0; p < msau_pkg::RAND_WORDS; p++) begin
         r_word[p] = req_data.rand_word[p][CALC_BITS-1:0];
      end
   end

   // Cross products, low word only.
   always_comb begin
      for (int i = 0; i < msau_pkg::MAX_SHARES; i++) begin
         for (int j = 0; j < msau_pkg::MAX_SHARES; j++) begin
            prod[i][j] = a_word[i] * b_word[j];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < msau_pkg::MAX_SHARES; i++) begin
         result[i] = '0;
         if (i < SHARES) begin
            case (req_data.action) inside
               msau_pkg::ACT_ADD: begin
                  result[i] = a_word[i] + b_word[i];
               end
               msau_pkg::ACT_SUB: begin
                  result[i] = a_word[i] - b_word[i];
               end
               msau_pkg::ACT_MUL, msau_pkg::ACT_MUL_ALT: begin
                  // Own product, then the lower share of each pair adds the
                  // pair's mask and the upper one subtracts it.
                  result[i] = prod[i][i];
                  for (int j = 0; j < msau_pkg::MAX_SHARES; j++) begin
                     if (j != i && j < SHARES) begin
                        if (j > i) begin
                           result[i] = result[i] + prod[i][j] + r_word[i + j - 1];
                        end else begin
                           result[i] = result[i] + prod[i][j] - r_word[i + j - 1];
                        end
                     end
                  end
               end
               default: begin
                  result[i] = '0;
               end
            endcase
         end
      end
   end

   always_comb begin
      for (int i = 0; i < msau_pkg::MAX_SHARES; i++) begin
         rsp_data.out_share[i] = msau_pkg::FIELD_BITS'(result[i]);
      end
   end

endmodule

`default_nettype wire

FILE: design/masked_share_arith_unit.sv
// Masked share arithmetic unit: a request beat passes the input register, the cross
// product array of msau_share_alu and the result register behind it to the response
// beat; throughput 1 beat per cycle while the response side does not stall.
// Reset (synchronous, active high) empties both stages; payload is not reset.
// Depends on msau_pkg, msau_req_if, msau_rsp_if and msau_share_alu.
`default_nettype none

module masked_share_arith_unit #(
   parameter int SHARES    = 3,
   parameter int WORD_BITS = 32
) (
   input  wire          clock,
   input  wire          reset,
   msau_req_if.sink     req_bus,
   msau_rsp_if.source   rsp_bus
);

   // Stage 1 holds the accepted request, stage 2 holds the finished result.
   logic                      s1_valid_ff, s1_valid_in;
   msau_pkg::req_payload_type s1_data_ff,  s1_data_in;
   logic                      s2_valid_ff, s2_valid_in;
   msau_pkg::rsp_payload_type s2_data_ff,  s2_data_in;

   msau_pkg::req_payload_type req_data;
   msau_pkg::rsp_payload_type alu_data;

   logic s1_ready;
   logic s2_ready;

   // Pack the request beat.
   always_comb begin
      req_data.action       = req_bus.action;
      req_data.a_share[0]   = req_bus.a_share0;
      req_data.a_share[1]   = req_bus.a_share1;
      req_data.a_share[2]   = req_bus.a_share2;
      req_data.b_share[0]   = req_bus.b_share0;
      req_data.b_share[1]   = req_bus.b_share1;
      req_data.b_share[2]   = req_bus.b_share2;
      req_data.rand_word[0] = req_bus.rand_01;
      req_data.rand_word[1] = req_bus.rand_02;
      req_data.rand_word[2] = req_bus.rand_12;
   end

   // Each stage takes a new beat when it is empty or drains this cycle, so
   // a stalled response does not block the stage in front while it is free.
   assign s2_ready      = !s2_valid_ff || rsp_bus.ready;
   assign s1_ready      = !s1_valid_ff || s2_ready;
   assign req_bus.ready = s1_ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      if (s1_ready) begin
         s1_valid_in = req_bus.valid;
         s1_data_in  = req_data;
      end
   end

   msau_share_alu #(
      .SHARES    (SHARES),
      .WORD_BITS (WORD_BITS)
   ) u_share_alu (
      .req_data (s1_data_ff),
      .rsp_data (alu_data)
   );

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_data_in  = s2_data_ff;
      if (s2_ready) begin
         s2_valid_in = s1_valid_ff;
         s2_data_in  = alu_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      s2_data_ff <= s2_data_in;
   end

   assign rsp_bus.valid      = s2_valid_ff;
   assign rsp_bus.out_share0 = s2_data_ff.out_share[0];
   assign rsp_bus.out_share1 = s2_data_ff.out_share[1];
   assign rsp_bus.out_share2 = s2_data_ff.out_share[2];

endmodule

`default_nettype wire

FILE: design/msau_port_checker.sv
// Port-level checks of the masked share arithmetic unit, bound to its top level.
// Depends on masked_share_arith_unit_defines.svh and msau_pkg.
`default_nettype none

`include "masked_share_arith_unit_defines.svh"

module msau_port_checker (
   input wire                      clock,
   input wire                      reset,
   input wire                      req_valid,
   input wire                      req_ready,
   input wire                      rsp_valid,
   input wire                      rsp_ready,
   input wire msau_pkg::field_type out_share0,
   input wire msau_pkg::field_type out_share1,
   input wire msau_pkg::field_type out_share2
);

   logic                                req_fire;
   logic [3*msau_pkg::FIELD_BITS-1:0]   out_shares;

   assign req_fire   = req_valid && req_ready;
   assign out_shares = {out_share2, out_share1, out_share0};

   // A stalled response beat keeps its shares.
   `MSAU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(out_shares))

   // Reset leaves no response pending.
   `MSAU_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

   // With the result stage empty the unit always takes a request.
   `MSAU_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)

   // No response appears unless one was already pending or a request beat was taken early enough to pass both stages.
   `MSAU_ASSERT_NOW(a_no_phantom, clock, reset, !$past(rsp_valid) && !$past(req_fire) && !$past(req_fire, 2), !rsp_valid)

endmodule

bind masked_share_arith_unit msau_port_checker u_port_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .out_share0 (rsp_bus.out_share0),
   .out_share1 (rsp_bus.out_share1),
   .out_share2 (rsp_bus.out_share2)
);

`default_nettype wire

FILE: sim/masked_share_arith_unit_tb.sv
// Self-checking testbench for masked_share_arith_unit: a directed table, then random beats.
// Each result is checked against its table value or a share-wise predictor. Depends on msau_pkg,
// msau_req_if, msau_rsp_if and the unit itself.

module masked_share_arith_unit_tb;

   localparam int SHARES         = 3;
   localparam int WORD_BITS      = 32;
   localparam int RANDOM_BEATS   = 550;
   localparam int IDLE_PERCENT   = 36;
   localparam int HOLDOFF_CYCLES = 60;
   localparam int WATCHDOG_LIMIT = 600;
   localparam int DRAIN_CYCLES   = 6;
   localparam int REPORT_LIMIT   = 10;

   // Result shares are reduced to the word width before they leave the unit.
   localparam msau_pkg::field_type WORD_MASK = (WORD_BITS >= msau_pkg::FIELD_BITS) ? '1 :
                                               msau_pkg::field_type'((64'd1 << WORD_BITS) - 64'd1);

   // Three shares packed with share 0 at index 0, so {s2, s1, s0} reads right to left.
   typedef logic [msau_pkg::MAX_SHARES-1:0][msau_pkg::FIELD_BITS-1:0] share_triple_type;

   typedef struct {
      msau_pkg::req_payload_type beat;
      bit                        known;
      share_triple_type          want;
   } directed_row_type;

   typedef struct {
      bit               known;
      share_triple_type want;
   } typed_shares_type;

   logic clock;
   logic reset;

   msau_req_if req_bus ();
   msau_rsp_if rsp_bus ();

   masked_share_arith_unit #(
      .SHARES    (SHARES),
      .WORD_BITS (WORD_BITS)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Typed answers in send order; the monitor pops one per accepted request beat.
   typed_shares_type   typed_shares_q[$];
   // Shares still owed by the unit, oldest first.
   share_triple_type   expected_shares_q[$];
   directed_row_type   directed_rows[$];

   int  fail_count      = 0;
   int  report_count    = 0;
   int  results_checked = 0;
   int  stalled_cycles  = 0;
   bit  holdoff_used    = 1'b0;
   int  holdoff_left    = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Share-wise add/sub, or the independent masked product for either multiply code.
   // Pair order of the random words is (0,1), (0,2), (1,2).
   function automatic share_triple_type predict_shares(input msau_pkg::req_payload_type beat);
      share_triple_type res;
      int               pair;
      res  = '0;
      pair = 0;
      if (beat.action == msau_pkg::ACT_MUL || beat.action == msau_pkg::ACT_MUL_ALT) begin
         for (int i = 0; i < SHARES; i++)
            res[i] = beat.a_share[i] * beat.b_share[i];
         for (int i = 0; i < SHARES; i++) begin
            for (int j = i + 1; j < SHARES; j++) begin
               res[i] = res[i] + beat.a_share[i] * beat.b_share[j] + beat.rand_word[pair];
               res[j] = res[j] + beat.a_share[j] * beat.b_share[i] - beat.rand_word[pair];
               pair++;
            end
         end
      end else if (beat.action == msau_pkg::ACT_SUB) begin
         for (int i = 0; i < SHARES; i++)
            res[i] = beat.a_share[i] - beat.b_share[i];
      end else begin
         for (int i = 0; i < SHARES; i++)
            res[i] = beat.a_share[i] + beat.b_share[i];
      end
      for (int i = 0; i < msau_pkg::MAX_SHARES; i++)
         res[i] = res[i] & WORD_MASK;
      return res;
   endfunction

   function automatic directed_row_type table_row(
      input logic [msau_pkg::ACTION_BITS-1:0] act,
      input share_triple_type a, input share_triple_type b,
      input share_triple_type r, input bit known,
      input share_triple_type want);
      directed_row_type row;
      row.beat.action    = act;
      row.beat.a_share   = a;
      row.beat.b_share   = b;
      row.beat.rand_word = r;
      row.known          = known;
      row.want           = want;
      return row;
   endfunction

   // Mostly uniform, with the extremes and single set bits mixed in.
   function automatic msau_pkg::field_type random_field();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         2:       return msau_pkg::field_type'(1) << $urandom_range(0, msau_pkg::FIELD_BITS - 1);
         default: return msau_pkg::field_type'($urandom);
      endcase
   endfunction

   task automatic send_beat(input msau_pkg::req_payload_type beat, input bit known,
                            input share_triple_type want, input bit may_idle);
      typed_shares_type entry;
      if (may_idle) begin
         while ($urandom_range(0, 99) < IDLE_PERCENT) begin
            req_bus.valid = 1'b0;
            @(negedge clock);
         end
      end
      entry.known = known;
      entry.want  = want;
      typed_shares_q.push_back(entry);
      req_bus.action   = beat.action;
      req_bus.a_share0 = beat.a_share[0];
      req_bus.a_share1 = beat.a_share[1];
      req_bus.a_share2 = beat.a_share[2];
      req_bus.b_share0 = beat.b_share[0];
      req_bus.b_share1 = beat.b_share[1];
      req_bus.b_share2 = beat.b_share[2];
      req_bus.rand_01  = beat.rand_word[0];
      req_bus.rand_02  = beat.rand_word[1];
      req_bus.rand_12  = beat.rand_word[2];
      req_bus.valid    = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic run_stimulus();
      msau_pkg::req_payload_type beat;
      bit                        calm;
      // Triples are written share 2 first; random words as {r12, r02, r01}.
      directed_rows.push_back(table_row(msau_pkg::ACT_ADD, {3{32'h0}}, {3{32'h0}},
                                        {3{32'h0}}, 1'b1, {3{32'h0}}));
      // add wraps to zero; random words have no effect on add/sub
      directed_rows.push_back(table_row(msau_pkg::ACT_ADD, {3{32'hFFFF_FFFF}}, {3{32'h1}},
                                        {3{32'hFFFF_FFFF}}, 1'b1, {3{32'h0}}));
      directed_rows.push_back(table_row(msau_pkg::ACT_ADD, {3{32'hFFFF_FFFF}},
                                        {3{32'hFFFF_FFFF}}, {3{32'h0}}, 1'b1,
                                        {3{32'hFFFF_FFFE}}));
      directed_rows.push_back(table_row(msau_pkg::ACT_SUB, {3{32'h0}}, {3{32'h1}},
                                        {3{32'h0}}, 1'b1, {3{32'hFFFF_FFFF}}));
      directed_rows.push_back(table_row(msau_pkg::ACT_SUB, {3{32'hFFFF_FFFF}}, {3{32'h0}},
                                        {3{32'hFFFF_FFFF}}, 1'b1, {3{32'hFFFF_FFFF}}));
      directed_rows.push_back(table_row(msau_pkg::ACT_SUB, {3{32'h8000_0000}},
                                        {3{32'h8000_0000}}, {3{32'h0}}, 1'b1,
                                        {3{32'h0}}));
      directed_rows.push_back(table_row(msau_pkg::ACT_MUL, {3{32'h0}}, {3{32'h0}},
                                        {3{32'h0}}, 1'b1, {3{32'h0}}));
      // every share collects its own product plus two cross terms: 3
      directed_rows.push_back(table_row(msau_pkg::ACT_MUL, {3{32'h1}}, {3{32'h1}},
                                        {3{32'h0}}, 1'b1, {3{32'h3}}));
      directed_rows.push_back(table_row(msau_pkg::ACT_MUL, {3{32'hFFFF_FFFF}},
                                        {3{32'hFFFF_FFFF}}, {3{32'h0}}, 1'b1,
                                        {3{32'h3}}));
      // zero operand: only the random words survive, +r on the low share, -r on the high
      directed_rows.push_back(table_row(msau_pkg::ACT_MUL, {3{32'h0}}, {3{32'hFFFF_FFFF}},
                                        {32'h0, 32'h7, 32'h5}, 1'b1,
                                        {32'hFFFF_FFF9, 32'hFFFF_FFFB, 32'h0000_000C}));
      // spare code multiplies as well
      directed_rows.push_back(table_row(msau_pkg::ACT_MUL_ALT, {3{32'h0}},
                                        {3{32'hFFFF_FFFF}}, {32'h0, 32'h7, 32'h5}, 1'b1,
                                        {32'hFFFF_FFF9, 32'hFFFF_FFFB, 32'h0000_000C}));
      directed_rows.push_back(table_row(msau_pkg::ACT_MUL, {3{32'h0}}, {3{32'h0}},
                                        {3{32'hFFFF_FFFF}}, 1'b1,
                                        {32'h0000_0002, 32'h0000_0000, 32'hFFFF_FFFE}));
      directed_rows.push_back(table_row(msau_pkg::ACT_MUL, {32'h3, 32'h2, 32'h1},
                                        {32'h6, 32'h5, 32'h4},
                                        {32'd30, 32'd20, 32'd10}, 1'b0, '0));
      directed_rows.push_back(table_row(msau_pkg::ACT_MUL,
                                        {32'hDEAD_BEEF, 32'h0123_4567, 32'h89AB_CDEF},
                                        {32'hFEDC_BA98, 32'h7654_3210, 32'hCAFE_F00D},
                                        {32'h1357_9BDF, 32'h2468_ACE0, 32'h0F0F_0F0F},
                                        1'b0, '0));
      directed_rows.push_back(table_row(msau_pkg::ACT_MUL_ALT,
                                        {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF},
                                        {32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001},
                                        {32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF},
                                        1'b0, '0));
      directed_rows.push_back(table_row(msau_pkg::ACT_SUB,
                                        {32'h1234_5678, 32'h0000_0001, 32'hAAAA_AAAA},
                                        {32'h8765_4321, 32'hFFFF_FFFF, 32'h5555_5555},
                                        {3{32'h0}}, 1'b0, '0));
      directed_rows.push_back(table_row(msau_pkg::ACT_ADD,
                                        {32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF},
                                        {32'hAAAA_AAAA, 32'h5555_5556, 32'h0000_0001},
                                        {32'hDEAD_BEEF, 32'h0, 32'hFFFF_FFFF}, 1'b0, '0));

      foreach (directed_rows[k])
         send_beat(directed_rows[k].beat, directed_rows[k].known, directed_rows[k].want, 1'b1);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         beat.action = msau_pkg::ACTION_BITS'($urandom_range(0, 3));
         for (int s = 0; s < msau_pkg::MAX_SHARES; s++) begin
            beat.a_share[s] = random_field();
            beat.b_share[s] = random_field();
         end
         for (int p = 0; p < msau_pkg::RAND_WORDS; p++)
            beat.rand_word[p] = random_field();
         // back-to-back window so the pipeline runs at full rate for a while
         calm = (n >= 130 && n < 240);
         send_beat(beat, 1'b0, '0, !calm);
      end
      req_bus.valid = 1'b0;

      wait (expected_shares_q.size() == 0 && typed_shares_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Monitor: log request beats, check response beats, and track idle cycles.
   always @(posedge clock) begin : monitor
      msau_pkg::req_payload_type beat;
      typed_shares_type          entry;
      share_triple_type          want;
      share_triple_type          got;
      bit                        req_fire;
      bit                        rsp_fire;
      req_fire = req_bus.valid && req_bus.ready;
      rsp_fire = rsp_bus.valid && rsp_bus.ready;
      if (reset) begin
         stalled_cycles = 0;
      end else begin
         if (req_fire) begin
            beat.action       = req_bus.action;
            beat.a_share[0]   = req_bus.a_share0;
            beat.a_share[1]   = req_bus.a_share1;
            beat.a_share[2]   = req_bus.a_share2;
            beat.b_share[0]   = req_bus.b_share0;
            beat.b_share[1]   = req_bus.b_share1;
            beat.b_share[2]   = req_bus.b_share2;
            beat.rand_word[0] = req_bus.rand_01;
            beat.rand_word[1] = req_bus.rand_02;
            beat.rand_word[2] = req_bus.rand_12;
            entry = typed_shares_q.pop_front();
            expected_shares_q.push_back(entry.known ? entry.want : predict_shares(beat));
         end
         if (rsp_fire) begin
            got = {rsp_bus.out_share2, rsp_bus.out_share1, rsp_bus.out_share0};
            if (expected_shares_q.size() == 0) begin
               fail_count++;
               if (report_count < REPORT_LIMIT) begin
                  report_count++;
                  $display("unexpected result beat: %h %h %h", got[0], got[1], got[2]);
               end
            end else begin
               want = expected_shares_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (report_count < REPORT_LIMIT) begin
                     report_count++;
                     $display("result %0d: expected %h %h %h, got %h %h %h", results_checked,
                              want[0], want[1], want[2], got[0], got[1], got[2]);
                  end
               end
            end
            results_checked++;
         end
         if (req_fire || rsp_fire)
            stalled_cycles = 0;
         else
            stalled_cycles++;
      end
   end

   // Receiver: random stalls, a stall-free window, and one long hold-off so the
   // unit backs up and drops req ready while the sender keeps offering.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_bus.ready = 1'b0;
         end else if (holdoff_left != 0) begin
            rsp_bus.ready = 1'b0;
            holdoff_left--;
         end else if (!holdoff_used && results_checked >= 320) begin
            holdoff_used  = 1'b1;
            holdoff_left  = HOLDOFF_CYCLES - 1;
            rsp_bus.ready = 1'b0;
         end else if (results_checked >= 150 && results_checked < 260) begin
            rsp_bus.ready = 1'b1;
         end else begin
            rsp_bus.ready = ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.action   = msau_pkg::ACT_ADD;
      req_bus.a_share0 = '0;
      req_bus.a_share1 = '0;
      req_bus.a_share2 = '0;
      req_bus.b_share0 = '0;
      req_bus.b_share1 = '0;
      req_bus.b_share2 = '0;
      req_bus.rand_01  = '0;
      req_bus.rand_02  = '0;
      req_bus.rand_12  = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      fork
         run_stimulus();
         wait (stalled_cycles >= WATCHDOG_LIMIT);
      join_any

      // watchdog expiry and results still owed both count as failures
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
         fail_count++;
         $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
      end
      if (expected_shares_q.size() != 0 || typed_shares_q.size() != 0)
         fail_count++;

      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
